>>> hw/rtl/u2da_pkg.sv
// Shared constants and the double-dabble step function for the decimal text core.
// No dependencies; used by the core and its checker.
package u2da_pkg;

  localparam int unsigned BIN_W           = 32;
  localparam int unsigned NUM_DIGITS      = 10;
  localparam int unsigned BCD_W           = 4 * NUM_DIGITS;
  localparam int unsigned WORK_W          = BCD_W + BIN_W;
  localparam int unsigned STEPS_PER_STAGE = 4;
  localparam int unsigned NUM_STAGES      = BIN_W / STEPS_PER_STAGE;
  localparam int unsigned POS_W           = $clog2(NUM_DIGITS);
  localparam int unsigned CHAR_W          = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

  typedef logic [WORK_W-1:0] work_t;
  typedef logic [BCD_W-1:0]  bcd_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Several shift-and-add-3 steps. The BCD digits sit above the binary bits,
  // so each step corrects the digits and then shifts the whole word left.
  function automatic work_t dabble_steps(input work_t x);
    work_t      w;
    logic [3:0] d;
    w = x;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        d = w[BIN_W + 4*k +: 4];
        if (d >= 4'd5) begin
          w[BIN_W + 4*k +: 4] = d + 4'd3;
        end
      end
      w = {w[WORK_W-2:0], 1'b0};
    end
    return w;
  endfunction

endpackage

>>> hw/rtl/unsigned_to_decimal_ascii_core.sv
// Top level: converts a 32-bit unsigned word into decimal ASCII digit words.
// Depends on u2da_pkg for constants and the double-dabble step function.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   value[31:0]
//   output    out_valid / out_stall digit_char[5:0], last_digit
//
// An input word passes eight pipeline stages of four double-dabble steps each,
// then a serializer sends one digit word per cycle while out_stall is low, most significant first.
// One input word therefore occupies the serializer for one digit word per digit (1 to 10);
// its first digit is offered once the word has left the last stage and been loaded there.
// Reset is synchronous and clears all valid bits and the serializer.
// Stalls back up through the pipeline stage by stage; no word is lost or repeated.
module unsigned_to_decimal_ascii_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [u2da_pkg::BIN_W-1:0]  value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [u2da_pkg::CHAR_W-1:0] digit_char,
  output logic                        last_digit
);

  u2da_pkg::work_t pipe    [u2da_pkg::NUM_STAGES];
  logic            pipe_v  [u2da_pkg::NUM_STAGES];
  logic            stage_ready [u2da_pkg::NUM_STAGES+1];

  logic            busy;
  u2da_pkg::bcd_t  digits;
  u2da_pkg::pos_t  pos;
  u2da_pkg::pos_t  msd;
  u2da_pkg::bcd_t  tail_bcd;
  logic            out_take;
  logic            load_ok;

  assign tail_bcd = pipe[u2da_pkg::NUM_STAGES-1][u2da_pkg::WORK_W-1:u2da_pkg::BIN_W];
  assign out_take = busy && !out_stall;
  assign load_ok  = !busy || (out_take && (pos == '0));

  // A stage may take new data when it is empty or its contents move on.
  always_comb begin
    stage_ready[u2da_pkg::NUM_STAGES] = load_ok;
    for (int i = u2da_pkg::NUM_STAGES - 1; i >= 0; i--) begin
      stage_ready[i] = !pipe_v[i] || stage_ready[i+1];
    end
  end

  assign in_stall = !stage_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < u2da_pkg::NUM_STAGES; i++) begin
        pipe_v[i] <= 1'b0;
      end
    end else begin
      if (stage_ready[0]) begin
        pipe_v[0] <= in_valid;
      end
      for (int i = 1; i < u2da_pkg::NUM_STAGES; i++) begin
        if (stage_ready[i]) begin
          pipe_v[i] <= pipe_v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[0]) begin
      pipe[0] <= u2da_pkg::dabble_steps({{u2da_pkg::BCD_W{1'b0}}, value});
    end
    for (int i = 1; i < u2da_pkg::NUM_STAGES; i++) begin
      if (stage_ready[i]) begin
        pipe[i] <= u2da_pkg::dabble_steps(pipe[i-1]);
      end
    end
  end

  // Position of the most significant nonzero digit; zero keeps position 0.
  always_comb begin
    msd = '0;
    for (int k = 1; k < u2da_pkg::NUM_DIGITS; k++) begin
      if (tail_bcd[4*k +: 4] != 4'd0) begin
        msd = u2da_pkg::POS_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (load_ok && pipe_v[u2da_pkg::NUM_STAGES-1]) begin
      busy <= 1'b1;
      pos  <= msd;
    end else if (out_take && (pos == '0)) begin
      busy <= 1'b0;
    end else if (out_take) begin
      pos <= pos - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && pipe_v[u2da_pkg::NUM_STAGES-1]) begin
      digits <= tail_bcd;
    end
  end

  assign out_valid  = busy;
  assign digit_char = u2da_pkg::ASCII_ZERO + {2'b00, digits[4*pos +: 4]};
  assign last_digit = (pos == '0);

endmodule

>>> hw/rtl/u2da_checker.sv
// Port-level checker for the decimal text core, bound to the top level below.
// Depends on u2da_pkg for the port widths and the ASCII digit range.
module u2da_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [u2da_pkg::BIN_W-1:0]  value,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [u2da_pkg::CHAR_W-1:0] digit_char,
  input logic                        last_digit
);

  // A stalled output word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digit_char) && $stable(last_digit))
    else $error("output word changed while stalled");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= u2da_pkg::ASCII_ZERO) &&
                  (digit_char <= u2da_pkg::ASCII_NINE))
    else $error("output character is not a decimal digit");

  // Digits of one number follow each other without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_digit |=> out_valid)
    else $error("gap inside a number's digits");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(value))
    else $error("input word changed while stalled");

endmodule

bind unsigned_to_decimal_ascii_core u2da_checker u_checker (.*);
